// ===== src/psba_pkg.sv =====
package psba_pkg;

  // Default sizing
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned MAX_SEGMENTS_DEF = 128;

  // Field and port widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SEG_LOG2_W  = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 40;
  localparam int unsigned ROW_BITS    = 8;

  localparam logic [SEG_LOG2_W-1:0] SEG_LOG2_RST  = 4'd12;
  localparam logic [ADDR_W-1:0]     PAGE_BASE_RST = 32'd0;

  // Request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LOG2  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BASE = 1'd1;

  // Controller to datapath
  typedef struct packed {
    logic take_in;  // latch an input beat
    logic prep;     // range checks, pick first row
    logic eval;     // examine the row read back
    logic load_out; // move the result into the output register
  } psba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early_done; // result settled without touching the map
    logic eval_done;  // search or free finished this cycle
    logic out_free;   // output register can take a result
  } psba_sts_t;

endpackage

// ===== src/psba_ram.sv =====
module psba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/psba_ctrl.sv =====
module psba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psba_pkg::psba_sts_t sts_i,
  output psba_pkg::psba_cmd_t cmd_o
);
  import psba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.take_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.early_done ? S_DONE : S_READ;
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (sts_i.eval_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.load_out = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/psba_dp.sv =====
module psba_dp #(
  parameter int unsigned PAGE_BYTES   = psba_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_SEGMENTS = psba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [psba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input beat
  input  logic                                in_op_i,
  input  logic [psba_pkg::ADDR_W-1:0]         in_addr_i,
  // output beat
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [psba_pkg::ADDR_W-1:0]         out_addr_o,
  output logic [psba_pkg::STATUS_W-1:0]       out_status_o,
  // control
  input  psba_pkg::psba_cmd_t                 cmd_i,
  output psba_pkg::psba_sts_t                 sts_o
);
  import psba_pkg::*;

  localparam int unsigned ROWS = (MAX_SEGMENTS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BW   = $clog2(ROW_BITS);

  // Configuration registers
  logic [SEG_LOG2_W-1:0] seg_log2_q;
  logic [ADDR_W-1:0]     page_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_log2_q  <= SEG_LOG2_RST;
      page_base_q <= PAGE_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEG_LOG2:  seg_log2_q  <= cfg_data_i[SEG_LOG2_W-1:0];
        REG_PAGE_BASE: page_base_q <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment count, capped at the map size
  logic [31:0] raw_count;
  logic [31:0] count;
  logic [31:0] span;
  logic [31:0] align_mask;

  always_comb begin
    raw_count  = 32'(PAGE_BYTES) >> seg_log2_q;
    count      = (raw_count > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS) : raw_count;
    span       = count << seg_log2_q;
    align_mask = (32'd1 << seg_log2_q) - 32'd1;
  end

  // Request registers
  logic              op_q;
  logic [ADDR_W-1:0] off_q;
  logic [RW-1:0]     row_q;
  logic [RW-1:0]     row_d;
  logic [BW-1:0]     bit_q;
  logic [BW-1:0]     bit_d;
  logic [ADDR_W-1:0] res_addr_q;
  logic [ADDR_W-1:0] res_addr_d;
  logic [STATUS_W-1:0] res_status_q;
  logic [STATUS_W-1:0] res_status_d;

  // Used map: one row of eight segments per RAM word, row valid bits for reset
  logic [ROWS-1:0]     row_valid_q;
  logic [RW-1:0]       ram_raddr;
  logic [ROW_BITS-1:0] ram_rdata;
  logic                ram_we;
  logic [ROW_BITS-1:0] ram_wdata;
  logic [ROW_BITS-1:0] row_bits;

  psba_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // While scanning, fetch the next lower row ahead
  assign ram_raddr = cmd_i.eval ? (row_q - RW'(1)) : row_q;
  assign row_bits  = row_valid_q[row_q] ? ram_rdata : '0;

  // Prep stage checks
  logic [31:0] free_idx;
  logic        free_bad;
  logic        count_zero;

  always_comb begin
    free_idx   = off_q >> seg_log2_q;
    free_bad   = (off_q >= span) || ((off_q & align_mask) != 32'd0);
    count_zero = (count == 32'd0);
  end

  // Highest free in-range segment of the current row
  logic              hit;
  logic [BW-1:0]     hit_bit;
  logic [31:0]       seg_num;

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    seg_num = '0;
    for (int b = 0; b < ROW_BITS; b++) begin
      seg_num = (32'(row_q) << BW) | 32'(b);
      if ((seg_num < count) && !row_bits[b]) begin
        hit     = 1'b1;
        hit_bit = BW'(b);
      end
    end
  end

  logic [31:0] grant_seg;
  logic        bit_used;

  assign grant_seg = (32'(row_q) << BW) | 32'(hit_bit);
  assign bit_used  = row_bits[bit_q];

  always_comb begin
    row_d        = row_q;
    bit_d        = bit_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_wdata    = row_bits;
    sts_o        = '0;

    if (cmd_i.prep) begin
      res_addr_d = '0;
      if (op_q == OP_ALLOC) begin
        sts_o.early_done = count_zero;
        res_status_d     = ST_FULL;
        row_d            = RW'((count - 32'd1) >> BW);
      end else begin
        sts_o.early_done = free_bad;
        res_status_d     = ST_BAD_ADDR;
        row_d            = RW'(free_idx >> BW);
        bit_d            = free_idx[BW-1:0];
      end
    end

    if (cmd_i.eval) begin
      if (op_q == OP_ALLOC) begin
        if (hit) begin
          sts_o.eval_done = 1'b1;
          ram_we          = 1'b1;
          ram_wdata       = row_bits | (ROW_BITS'(1) << hit_bit);
          res_addr_d      = page_base_q + (grant_seg << seg_log2_q);
          res_status_d    = ST_OK;
        end else if (row_q == '0) begin
          sts_o.eval_done = 1'b1;
          res_status_d    = ST_FULL;
        end else begin
          row_d = row_q - RW'(1);
        end
      end else begin
        sts_o.eval_done = 1'b1;
        if (bit_used) begin
          ram_we       = 1'b1;
          ram_wdata    = row_bits & ~(ROW_BITS'(1) << bit_q);
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_NOT_USED;
        end
      end
    end

    sts_o.out_free = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      op_q  <= in_op_i;
      off_q <= in_addr_i - page_base_q;
    end
    row_q        <= row_d;
    bit_q        <= bit_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    if (cmd_i.load_out) begin
      out_addr_o   <= res_addr_q;
      out_status_o <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (ram_we) begin
        row_valid_q[row_q] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

// ===== src/page_segment_bitmap_allocator.sv =====
// Each request goes through prep, a map read and evaluation to done, which waits
// for a free output register; a bad free skips the read and evaluation. An allocate
// scans used-map rows (8 segments per row, one row per cycle through the map RAM
// read port, up to 16 rows at the default size). One request at a time; the next
// beat is taken in the cycle after the result is loaded, while that result may still
// wait at the output. Reset (rst_ni, asynchronous, active low) frees every segment at
// once via row valid bits, and sets segment_size_log2 to 12 and page_base to 0.
module page_segment_bitmap_allocator #(
  parameter int unsigned PAGE_BYTES   = psba_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_SEGMENTS = psba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [psba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [psba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [psba_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] segment_address
  input  logic                            s_axis_tuser,  // [0] operation
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [psba_pkg::M_TDATA_W-1:0]  m_axis_tdata   // [31:0] alloc_address,
                                                         // [33:32] status, [39:34] zero
);
  import psba_pkg::*;

  psba_cmd_t cmd;
  psba_sts_t sts;

  logic [ADDR_W-1:0]   out_addr;
  logic [STATUS_W-1:0] out_status;

  // The controller sequences each request: latch, check, scan or update, deliver.
  psba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, the used map and the address arithmetic.
  psba_dp #(
    .PAGE_BYTES   (PAGE_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser),
    .in_addr_i    (s_axis_tdata[ADDR_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_status_o (out_status),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // Pack the result beat; pad up to whole bytes with zeros.
  assign m_axis_tdata = {(M_TDATA_W - ADDR_W - STATUS_W)'(0), out_status, out_addr};

endmodule

// ===== src/psba_checker.sv =====
module psba_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [psba_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import psba_pkg::*;

  // One request at a time: after an accept the input stays closed through the prep state and the state after it
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input reopened too soon after accept");

  // Any failure reports a zero address
  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("failed request carries an address");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[39:34] == '0))
    else $error("result padding not zero");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind page_segment_bitmap_allocator psba_checker u_psba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
